@@ design/assert_macros.svh @@
// Assertion macros shared by the decoder modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ design/mwd_pkg.sv @@
// Shared types and constants of the Microwire command decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mwd_pkg;

   // Default limits of the address and data word widths.
   localparam int DEF_MAX_ADDRESS_BITS = 10;
   localparam int DEF_MAX_WORD_BITS    = 16;

   // Depth of the queue between front and back, in bundles.
   localparam int DEF_QUEUE_DEPTH = 4;

   // At most three results follow from one bus bit.
   localparam int RESULTS_MAX = 3;
   localparam int RCOUNT_W    = $clog2(RESULTS_MAX + 1);

   localparam int VALUE_W = 16;
   localparam int KIND_W  = 3;

   // Reset values of the configuration registers.
   localparam logic [3:0] ADDRESS_BITS_RESET = 4'd8;
   localparam logic [4:0] WORD_BITS_RESET    = 5'd16;
   localparam int CSR_DATA_W = 5;

   // Configuration register indexes.
   localparam logic CSR_ADDRESS_BITS = 1'b0;
   localparam logic CSR_WORD_BITS    = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_COMMAND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADDRESS = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SI_WORD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SO_WORD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SHORT   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MISSING = 3'd5;

   // Opcodes as they come off the bus.
   localparam logic [1:0] OP_EXTENDED = 2'b00;
   localparam logic [1:0] OP_WRITE    = 2'b01;
   localparam logic [1:0] OP_READ     = 2'b10;
   localparam logic [1:0] OP_ERASE    = 2'b11;

   // Top two address bits of the extended opcode.
   localparam logic [1:0] EXT_WDS  = 2'b00;
   localparam logic [1:0] EXT_WRAL = 2'b01;
   localparam logic [1:0] EXT_ERAL = 2'b10;
   localparam logic [1:0] EXT_WEN  = 2'b11;

   // Decoded command codes.
   typedef enum logic [2:0] {
      CMD_READ  = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_ERASE = 3'd2,
      CMD_WEN   = 3'd3,
      CMD_WDS   = 3'd4,
      CMD_ERAL  = 3'd5,
      CMD_WRAL  = 3'd6
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } result_type;

   // All results caused by one bus bit, slot 0 first.
   typedef struct packed {
      logic [RCOUNT_W-1:0]              count;
      result_type [RESULTS_MAX-1:0]     res;
   } bundle_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ design/mwd_front.sv @@
// Front part: holds the configuration, tracks the packet and decodes each bit.
// Depends on mwd_pkg; pushes result bundles into the queue.
`timescale 1ns / 1ps
`default_nettype none

module mwd_front
   import mwd_pkg::*;
#(
   parameter int MAX_ADDRESS_BITS = DEF_MAX_ADDRESS_BITS,
   parameter int MAX_WORD_BITS    = DEF_MAX_WORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  bit_valid,
   input  wire logic                  si_bit,
   input  wire logic                  so_bit,
   input  wire logic                  packet_end,
   input  wire queue_status_type      queue_status,
   output logic                       bit_ready,
   output logic                       push,
   output bundle_type                 push_bundle
);

   localparam int AB_W = $clog2(MAX_ADDRESS_BITS + 1);
   localparam int WB_W = $clog2(MAX_WORD_BITS + 1);
   localparam int WS_W = (MAX_WORD_BITS > VALUE_W) ? MAX_WORD_BITS : VALUE_W;

   logic [3:0]                  address_bits_ff;
   logic [4:0]                  word_bits_ff;
   logic [15:0]                 bit_index_ff, bit_index_in;
   logic [1:0]                  opcode_ff, opcode_in;
   logic [MAX_ADDRESS_BITS-1:0] address_ff, address_in;
   logic [WS_W-1:0]             word_ff, word_in;
   logic [WB_W-1:0]             wcount_ff, wcount_in;
   cmd_type                     command_ff, command_in;
   logic [AB_W-1:0]             ab;
   logic [WB_W-1:0]             wb;
   logic                        accept;

   assign bit_ready = !queue_status.full;
   assign accept    = bit_valid && bit_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         address_bits_ff <= ADDRESS_BITS_RESET;
         word_bits_ff    <= WORD_BITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADDRESS_BITS: address_bits_ff <= csr_wdata[3:0];
            CSR_WORD_BITS:    word_bits_ff    <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Effective widths, clamped to the supported range.
   always_comb begin
      if (address_bits_ff < 4'd2) begin
         ab = AB_W'(2);
      end else if (address_bits_ff > MAX_ADDRESS_BITS) begin
         ab = AB_W'(MAX_ADDRESS_BITS);
      end else begin
         ab = AB_W'(address_bits_ff);
      end
      if (word_bits_ff == 5'd0) begin
         wb = WB_W'(1);
      end else if (word_bits_ff > MAX_WORD_BITS) begin
         wb = WB_W'(MAX_WORD_BITS);
      end else begin
         wb = WB_W'(word_bits_ff);
      end
   end

   // Decode of one bus bit into the next packet state and its results.
   always_comb begin
      logic [MAX_ADDRESS_BITS-1:0] amask;
      logic [MAX_ADDRESS_BITS-1:0] addr_next;
      logic [MAX_ADDRESS_BITS-1:0] addr_top;
      logic [15:0]                 ab_end;
      logic [RCOUNT_W-1:0]         n;
      logic                        writes_word;

      bit_index_in = bit_index_ff;
      opcode_in    = opcode_ff;
      address_in   = address_ff;
      word_in      = word_ff;
      wcount_in    = wcount_ff;
      command_in   = command_ff;
      push_bundle  = '0;
      n            = '0;
      amask        = ~({MAX_ADDRESS_BITS{1'b1}} << ab);
      addr_next    = ({address_ff[MAX_ADDRESS_BITS-2:0], si_bit}) & amask;
      addr_top     = addr_next >> (ab - AB_W'(2));
      ab_end       = 16'(ab) + 16'd1;
      writes_word  = 1'b0;

      if (bit_index_ff < 16'd2) begin
         opcode_in = {opcode_ff[0], si_bit};
      end else if (bit_index_ff <= ab_end) begin
         address_in = addr_next;
         // The last address bit completes the command.
         if (bit_index_ff == ab_end) begin
            case (opcode_ff)
               OP_READ:  command_in = CMD_READ;
               OP_WRITE: command_in = CMD_WRITE;
               OP_ERASE: command_in = CMD_ERASE;
               default: begin
                  case (addr_top[1:0])
                     EXT_WEN:  command_in = CMD_WEN;
                     EXT_WDS:  command_in = CMD_WDS;
                     EXT_ERAL: command_in = CMD_ERAL;
                     default:  command_in = CMD_WRAL;
                  endcase
               end
            endcase
            push_bundle.res[n] = '{kind: KIND_COMMAND, value: VALUE_W'(command_in)};
            n = n + 1'b1;
            if (opcode_ff != OP_EXTENDED) begin
               push_bundle.res[n] = '{kind: KIND_ADDRESS, value: VALUE_W'(addr_next)};
               n = n + 1'b1;
            end
         end
      end else begin
         // Data phase: read words come from so, write words from si.
         writes_word = (command_ff == CMD_WRITE) || (command_ff == CMD_WRAL);
         if (command_ff == CMD_READ) begin
            word_in   = {word_ff[WS_W-2:0], so_bit};
            wcount_in = wcount_ff + 1'b1;
            if (wcount_in >= wb) begin
               push_bundle.res[n] = '{kind: KIND_SO_WORD, value: word_in[VALUE_W-1:0]};
               n = n + 1'b1;
               word_in   = '0;
               wcount_in = '0;
            end
         end else if (writes_word && (wcount_ff < wb)) begin
            word_in   = {word_ff[WS_W-2:0], si_bit};
            wcount_in = wcount_ff + 1'b1;
            if (wcount_in == wb) begin
               push_bundle.res[n] = '{kind: KIND_SI_WORD, value: word_in[VALUE_W-1:0]};
               n = n + 1'b1;
            end
         end
      end

      if (bit_index_ff != 16'hFFFF) begin
         bit_index_in = bit_index_ff + 16'd1;
      end

      // Packet end: warnings, then a fresh packet state.
      if (packet_end) begin
         if (bit_index_ff < ab_end) begin
            push_bundle.res[n] = '{kind: KIND_SHORT, value: '0};
            n = n + 1'b1;
         end else if (command_in == CMD_READ) begin
            if (wcount_in != '0) begin
               push_bundle.res[n] = '{kind: KIND_MISSING, value: '0};
               n = n + 1'b1;
            end
         end else if ((command_in == CMD_WRITE) || (command_in == CMD_WRAL)) begin
            if (wcount_in < wb) begin
               push_bundle.res[n] = '{kind: KIND_MISSING, value: '0};
               n = n + 1'b1;
            end
         end
         bit_index_in = '0;
         opcode_in    = '0;
         address_in   = '0;
         word_in      = '0;
         wcount_in    = '0;
         command_in   = CMD_READ;
      end

      push_bundle.count = n;
   end

   assign push = accept && (push_bundle.count != '0);

   // Packet state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_index_ff <= '0;
         opcode_ff    <= '0;
         address_ff   <= '0;
         word_ff      <= '0;
         wcount_ff    <= '0;
         command_ff   <= CMD_READ;
      end else if (accept) begin
         bit_index_ff <= bit_index_in;
         opcode_ff    <= opcode_in;
         address_ff   <= address_in;
         word_ff      <= word_in;
         wcount_ff    <= wcount_in;
         command_ff   <= command_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mwd_queue.sv @@
// Short queue of result bundles between the front and the back.
// Depends on mwd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwd_queue
   import mwd_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_bundle,
   input  wire logic       pop,
   output bundle_type      head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue over depth")
   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && status.full), "push while full")
   `ASSERT_NEXT(a_push_grows, clock, reset, !reset && do_push && !do_pop,
                count_ff == $past(count_ff) + 1'b1, "push did not grow queue")
   `ASSERT_ALWAYS(a_ptr_match, clock, reset,
                  (count_ff == '0 || count_ff == CNT_W'(DEPTH)) == (wr_ptr_ff == rd_ptr_ff),
                  "pointers disagree with fill count")

endmodule

`default_nettype wire

@@ design/mwd_back.sv @@
// Back part: takes bundles from the queue and sends their results one per word.
// Depends on mwd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwd_back
   import mwd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bundle_type        head,
   input  wire queue_status_type  queue_status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [VALUE_W-1:0]     rsp_tdata,
   output logic [KIND_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast
);

   bundle_type          bundle_ff;
   logic [RCOUNT_W-1:0] pos_ff, pos_in;
   logic                valid_ff, valid_in;
   logic                take, last_of, load;
   result_type          cur;

   assign cur        = bundle_ff.res[pos_ff];
   assign last_of    = ((pos_ff + 1'b1) == bundle_ff.count);
   assign take       = valid_ff && rsp_tready;
   assign load       = (!valid_ff || (take && last_of)) && !queue_status.empty;
   assign pop        = load;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = cur.value;
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = last_of;

   // Step through the bundle; load the next one as the last word leaves.
   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = '0;
      end else if (take) begin
         if (last_of) begin
            valid_in = 1'b0;
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= head;
      end
   end

   `ASSERT_ALWAYS(a_pos_in_bundle, clock, reset, !valid_ff || (pos_ff < bundle_ff.count),
                  "slot beyond bundle")
   `ASSERT_ALWAYS(a_bundle_nonempty, clock, reset, !valid_ff || (bundle_ff.count != '0),
                  "empty bundle held")
   `ASSERT_NEXT(a_step_on, clock, reset, !reset && take && !last_of,
                valid_ff && (pos_ff == $past(pos_ff) + 1'b1), "slot did not advance")

endmodule

`default_nettype wire

@@ design/microwire_eeprom_command_decoder.sv @@
// Top level of the Microwire EEPROM command decoder.
// Depends on mwd_pkg, mwd_front, mwd_queue and mwd_back.
//
// Usage:
//   req_ carries one bus bit per word: req_tdata[0] is si, req_tdata[1] is so,
//   req_tlast marks the last bit of a packet (start bit already removed).
//   rsp_ carries results: rsp_tdata is the command code, address or data word,
//   rsp_tuser the result kind, rsp_tlast marks the last result of one bit.
//   csr_ writes address_bits (index 0) and word_bits (index 1).
// Throughput: one bit is accepted every cycle while the result queue has room.
//   The back sends one result per cycle while rsp_tready is high; bits with no
//   result push nothing into the queue. The output side sets the bound.
// Path: with the queue and the back empty, a bit's results are registered in the
//   queue and then in the back's bundle register, which drives rsp_.
// Stall: while rsp_tready is low the current result holds; up to four bundles
//   of results wait in the queue, after that req_tready falls.
// Reset: synchronous; clears the packet state and the queue and sets
//   address_bits to 8 and word_bits to 16.
`timescale 1ns / 1ps
`default_nettype none

module microwire_eeprom_command_decoder
   import mwd_pkg::*;
#(
   parameter int MAX_ADDRESS_BITS = DEF_MAX_ADDRESS_BITS,
   parameter int MAX_WORD_BITS    = DEF_MAX_WORD_BITS,
   parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration write port.
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // Bus bit input.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [0] si_bit, [1] so_bit, rest zero
   input  wire logic                  req_tlast,   // packet_end
   // Result output.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [VALUE_W-1:0]         rsp_tdata,   // [15:0] value
   output logic [KIND_W-1:0]          rsp_tuser,   // [2:0] kind
   output logic                       rsp_tlast    // run_last
);

   logic             push, pop;
   bundle_type       push_bundle, head;
   queue_status_type queue_status;

   // Front: configuration and bit decode.
   mwd_front #(
      .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS),
      .MAX_WORD_BITS   (MAX_WORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .bit_valid   (req_tvalid),
      .si_bit      (req_tdata[0]),
      .so_bit      (req_tdata[1]),
      .packet_end  (req_tlast),
      .queue_status(queue_status),
      .bit_ready   (req_tready),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // Queue of result bundles.
   mwd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_bundle(push_bundle),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   // Back: result serializer.
   mwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_status(queue_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ bench/microwire_eeprom_command_decoder_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the Microwire EEPROM command decoder: streams bus bits in,
// predicts every command, address, data word and warning, and checks the result words.
// Depends on mwd_pkg and the microwire_eeprom_command_decoder top level.

import mwd_pkg::*;

// One expected result word.
typedef struct packed {
   logic [KIND_W-1:0]  kind;
   logic [VALUE_W-1:0] value;
   logic               last;
} decoded_result_type;

// Tracks the decoder's packet state and keeps the results it still owes.
class packet_decode_tracker;
   logic [3:0]         address_bits_reg;
   logic [4:0]         word_bits_reg;
   logic [15:0]        bit_index;
   logic [1:0]         opcode;
   logic [9:0]         address_shift;
   logic [15:0]        word_shift;
   logic [4:0]         word_count;
   cmd_type            command;
   decoded_result_type owed_results[$];
   int                 mismatches;

   function new();
      address_bits_reg = ADDRESS_BITS_RESET;
      word_bits_reg    = WORD_BITS_RESET;
      mismatches       = 0;
      clear_packet();
   endfunction

   function void clear_packet();
      bit_index     = '0;
      opcode        = '0;
      address_shift = '0;
      word_shift    = '0;
      word_count    = '0;
      command       = CMD_READ;
   endfunction

   // Register values outside the supported range are clamped.
   function int effective_address_bits();
      if (address_bits_reg < 2) return 2;
      if (address_bits_reg > DEF_MAX_ADDRESS_BITS) return DEF_MAX_ADDRESS_BITS;
      return address_bits_reg;
   endfunction

   function int effective_word_bits();
      if (word_bits_reg < 1) return 1;
      if (word_bits_reg > DEF_MAX_WORD_BITS) return DEF_MAX_WORD_BITS;
      return word_bits_reg;
   endfunction

   function void write_register(logic index, logic [CSR_DATA_W-1:0] data);
      if (index == CSR_ADDRESS_BITS) address_bits_reg = data[3:0];
      else word_bits_reg = data;
   endfunction

   function int pending();
      return owed_results.size();
   endfunction

   function void owe(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
      decoded_result_type r;
      r.kind  = kind;
      r.value = value;
      r.last  = 1'b0;
      owed_results.push_back(r);
   endfunction

   // Advances the packet state by one accepted bus bit.
   function void note_bit(logic si, logic so, logic packet_end);
      int                 ab;
      int                 wb;
      int                 first;
      logic [15:0]        idx;
      logic [1:0]         top;
      decoded_result_type r;
      ab    = effective_address_bits();
      wb    = effective_word_bits();
      idx   = bit_index;
      first = owed_results.size();

      if (idx < 2) begin
         opcode = {opcode[0], si};
      end else if (idx < 2 + ab) begin
         address_shift = 10'(((int'(address_shift) << 1) | int'(si)) & ((1 << ab) - 1));
         // The last address bit completes the command.
         if (idx == 1 + ab) begin
            case (opcode)
               OP_READ:  command = CMD_READ;
               OP_WRITE: command = CMD_WRITE;
               OP_ERASE: command = CMD_ERASE;
               default: begin
                  top = 2'(address_shift >> (ab - 2));
                  case (top)
                     EXT_WEN:  command = CMD_WEN;
                     EXT_WDS:  command = CMD_WDS;
                     EXT_ERAL: command = CMD_ERAL;
                     default:  command = CMD_WRAL;
                  endcase
               end
            endcase
            owe(KIND_COMMAND, VALUE_W'(command));
            if (opcode != OP_EXTENDED) owe(KIND_ADDRESS, VALUE_W'(address_shift));
         end
      end else if (command == CMD_READ) begin
         // Reads keep collecting so words until the packet ends.
         word_shift = {word_shift[14:0], so};
         word_count++;
         if (word_count >= wb) begin
            owe(KIND_SO_WORD, word_shift);
            word_shift = '0;
            word_count = '0;
         end
      end else if ((command == CMD_WRITE || command == CMD_WRAL) && word_count < wb) begin
         word_shift = {word_shift[14:0], si};
         word_count++;
         if (word_count == wb) owe(KIND_SI_WORD, word_shift);
      end

      if (bit_index != 16'hFFFF) bit_index++;

      // Packet end: warn of a short packet or an incomplete word.
      if (packet_end) begin
         if (idx < 1 + ab) begin
            owe(KIND_SHORT, '0);
         end else if (command == CMD_READ) begin
            if (word_count > 0) owe(KIND_MISSING, '0);
         end else if (command == CMD_WRITE || command == CMD_WRAL) begin
            if (word_count < wb) owe(KIND_MISSING, '0);
         end
         clear_packet();
      end

      if (owed_results.size() > first) begin
         r = owed_results.pop_back();
         r.last = 1'b1;
         owed_results.push_back(r);
      end
   endfunction

   function void check_result(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                              logic last);
      decoded_result_type want;
      if (owed_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: kind %0d value %h last %b", kind, value, last);
         return;
      end
      want = owed_results.pop_front();
      if (want.kind !== kind || want.value !== value || want.last !== last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"result mismatch: expected kind %0d value %h last %b, ",
                      "got kind %0d value %h last %b"},
                     want.kind, want.value, want.last, kind, value, last);
      end
   endfunction
endclass

module microwire_eeprom_command_decoder_test;

   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_BITS    = 10;
   localparam int IDLE_LIMIT    = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VALUE_W-1:0]    rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   packet_decode_tracker tracker = new();

   int burst_left     = 0;
   int bits_sent      = 0;
   bit steady_sender  = 1'b0;
   bit hold_request   = 1'b0;
   int idle_cycles    = 0;

   int phase_address_bits [0:4] = '{15, 0, 6, 3, 8};
   int phase_word_bits    [0:4] = '{31, 0, 8, 5, 16};

   microwire_eeprom_command_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Zeros, ones or random bits for the data part of a packet.
   function automatic logic [63:0] fill_pattern();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one bus bit as a word, in bursts separated by random gaps.
   task automatic send_bit(input logic si, input logic so, input logic packet_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, so, si};
      req_tlast  <= packet_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_bit(si, so, packet_end);
      bits_sent++;
   endtask

   // Sends opcode and address MSB first, then data bits, cut to nbits in all.
   task automatic send_packet(input logic [1:0] op, input int address, input int nbits,
                              input logic [63:0] data, input logic [63:0] so_bits,
                              input bit end_mark);
      logic [63:0] head;
      logic [63:0] si_bits;
      int          ab;
      int          tail;
      ab   = tracker.effective_address_bits();
      head = (64'(op) << ab) | (64'(address) & ((64'd1 << ab) - 1));
      tail = nbits - ab - 2;
      if (tail >= 0) si_bits = (head << tail) | (data & ((64'd1 << tail) - 1));
      else si_bits = head >> (-tail);
      for (int i = 0; i < nbits; i++)
         send_bit(si_bits[nbits - 1 - i], so_bits[nbits - 1 - i],
                  end_mark && (i == nbits - 1));
   endtask

   // Waits until every owed result has arrived and the pipeline is quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on consecutive cycles; the block must be idle.
   task automatic set_config(input int address_bits, input int word_bits);
      csr_we    <= 1'b1;
      csr_index <= CSR_ADDRESS_BITS;
      csr_wdata <= CSR_DATA_W'(address_bits);
      @(posedge clock);
      tracker.write_register(CSR_ADDRESS_BITS, CSR_DATA_W'(address_bits));
      csr_index <= CSR_WORD_BITS;
      csr_wdata <= CSR_DATA_W'(word_bits);
      @(posedge clock);
      tracker.write_register(CSR_WORD_BITS, CSR_DATA_W'(word_bits));
      csr_we <= 1'b0;
   endtask

   // Result side: stalls on a changing pattern, or holds off on request.
   initial begin
      int cyc;
      int mode;
      cyc  = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (cyc % 40 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (cyc % 4 == 0);
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
         cyc++;
      end
   end

   // Every accepted result word is checked against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int          stop_at;
      int          nbits;
      int          pick;
      int          ab;
      int          wb;
      int          address;
      logic [1:0]  op;
      bit          end_mark;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed packets with a two-bit address (clamped up) and two-bit words.
      set_config(1, 2);
      send_packet(OP_READ, 3, 7, '0, '1, 1'b1);         // one so word, then a partial one
      send_packet(OP_WRITE, 0, 6, '1, '0, 1'b1);        // full si word of ones
      send_packet(OP_ERASE, 2, 5, '1, '0, 1'b1);        // extra bit after erase is ignored
      send_packet(OP_EXTENDED, EXT_WEN, 4, '0, '0, 1'b1);
      send_packet(OP_EXTENDED, EXT_WDS, 4, '0, '0, 1'b1);
      send_packet(OP_EXTENDED, EXT_ERAL, 4, '0, '0, 1'b1);
      send_packet(OP_EXTENDED, EXT_WRAL, 4, '0, '0, 1'b1);   // write-all with no data bits
      send_packet(OP_ERASE, 0, 1, '0, '0, 1'b1);        // packet ends on the first bit
      drain();

      // Back pressure: the result side holds off while one-bit packets pile up.
      hold_request  = 1'b1;
      steady_sender = 1'b1;
      repeat (24) send_packet(OP_READ, 0, 1, '0, '1, 1'b1);
      steady_sender = 1'b0;
      drain();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 5; phase++) begin
         set_config(phase_address_bits[phase], phase_word_bits[phase]);
         stop_at = bits_sent + PHASE_BITS;
         while (bits_sent < stop_at) begin
            ab       = tracker.effective_address_bits();
            wb       = tracker.effective_word_bits();
            pick     = $urandom_range(0, 99);
            op       = 2'($urandom);
            address  = $urandom;
            end_mark = ($urandom_range(0, 19) != 0);
            if (pick < 25) begin
               op    = OP_READ;
               nbits = 2 + ab + $urandom_range(0, 2) * wb +
                       ($urandom_range(0, 1) ? $urandom_range(0, wb - 1) : 0);
            end else if (pick < 45) begin
               op    = OP_WRITE;
               nbits = 2 + ab + wb;
               case ($urandom_range(0, 3))
                  2:       nbits -= $urandom_range(1, wb);
                  3:       nbits += $urandom_range(1, 3);
                  default: ;
               endcase
            end else if (pick < 55) begin
               op    = OP_ERASE;
               nbits = 2 + ab + $urandom_range(0, 2);
            end else if (pick < 80) begin
               op    = OP_EXTENDED;
               nbits = 2 + ab + ($urandom_range(0, 1) ? wb : $urandom_range(0, 3));
            end else if (pick < 90) begin
               nbits = $urandom_range(1, ab + 1);
            end else begin
               // Noise: random bits of random length.
               nbits = $urandom_range(1, 24);
            end
            send_packet(op, address, nbits, fill_pattern(), fill_pattern(), end_mark);
         end
         drain();
      end

      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
